>>> design/otcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ocean tide coefficient correction package
// Shared types, constants and arithmetic helpers of the correction block.
// ----------------------------------------------------------------------------
package otcc_pkg;

  // Highest harmonic degree that is accepted.
  localparam int NMAX = 15;

  // Widths of the data paths.
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CORR_W  = 40;
  localparam int STORE_W = 48;
  localparam int CORD_W  = 34;
  localparam int CORD_STEPS = 30;

  // Command codes of the input transaction.
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_CLR  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_POLE_M1 = 3'd6;
  localparam logic [2:0] REG_POLE_M2 = 3'd7;

  // CORDIC start value: the inverse of the rotation gain, Q2.30.
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Pole tide coefficients, scaled by 2^16.
  localparam logic signed [MUL_W-1:0] POLE_C_M1 = -33'sd365374210;
  localparam logic signed [MUL_W-1:0] POLE_C_M2 = 33'sd6299051;
  localparam logic signed [MUL_W-1:0] POLE_S_M1 = 33'sd9728383;
  localparam logic signed [MUL_W-1:0] POLE_S_M2 = -33'sd289104986;

  // Request from the sequencer to the correction store.
  typedef struct packed {
    logic                      clr;
    logic                      we;
    logic [7:0]                idx;
    logic signed [STORE_W-1:0] wcos;
    logic signed [STORE_W-1:0] wsin;
  } store_req_t;

  // Arctangent of 2^-i as a fraction of a turn, 2^32 per turn.
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      5'd24: v = 30'h00000029;
      5'd25: v = 30'h00000014;
      5'd26: v = 30'h0000000A;
      5'd27: v = 30'h00000005;
      5'd28: v = 30'h00000003;
      5'd29: v = 30'h00000001;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

  // Saturate a 49-bit sum to signed 48 bits.
  function automatic logic signed [STORE_W-1:0] sat48(input logic signed [STORE_W:0] v);
    logic signed [STORE_W-1:0] r;
    if (v[STORE_W] != v[STORE_W-1]) begin
      r = v[STORE_W] ? {1'b1, {(STORE_W-1){1'b0}}} : {1'b0, {(STORE_W-1){1'b1}}};
    end else begin
      r = v[STORE_W-1:0];
    end
    return r;
  endfunction

  // Saturating signed 64-bit add.
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/ocean_tide_coeff_correction.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ocean tide coefficient correction
// Accumulates ocean tide corrections of geopotential coefficients and returns
// corrected coefficient pairs, with the pole tide at degree 2 order 1.
// ----------------------------------------------------------------------------
// One transaction at a time is worked by a small sequencer around a shared
// 33x33 multiplier and an iterative CORDIC. An add row whose tide id matches
// the cached angle needs four products, two at order zero; one with a new
// tide id also forms the argument with six products and runs the CORDIC, one
// micro-rotation a cycle. A read adds the stored correction to the base, and
// at degree 2 order 1 needs four more products for the pole tide. The store
// clears at once on reset and on clear through per-entry valid bits. A
// finished result waits in the output register without blocking the next
// transaction from being accepted.
module ocean_tide_coeff_correction #(
  parameter int NMAX = otcc_pkg::NMAX
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_command,
  input  wire logic [7:0]         in_tide_id,
  input  wire logic [7:0]         in_degree,
  input  wire logic [7:0]         in_order,
  input  wire logic [23:0]        in_doodson_multipliers,
  input  wire logic signed [31:0] in_cos_plus_amp,
  input  wire logic signed [31:0] in_sin_plus_amp,
  input  wire logic signed [31:0] in_cos_minus_amp,
  input  wire logic signed [31:0] in_sin_minus_amp,
  input  wire logic signed [63:0] in_base_cos_coeff,
  input  wire logic signed [63:0] in_base_sin_coeff,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_status,
  output logic signed [63:0]      out_corrected_cos_coeff,
  output logic signed [63:0]      out_corrected_sin_coeff
);

  localparam int MW = otcc_pkg::MUL_W;
  localparam int PW = otcc_pkg::PROD_W;
  localparam int CW = otcc_pkg::CORR_W;
  localparam int SW = otcc_pkg::STORE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_TH_MUL, S_TH_ACC, S_CORD_GO, S_CORD_WAIT,
    S_MUL, S_ACC, S_WRITE, S_RD_WAIT, S_RD_SUM, S_RD_POLE, S_OUT
  } state_t;

  state_t               state_r;
  logic [2:0]           cnt_r;
  logic [1:0]           cmd_r;
  logic [7:0]           deg_r;
  logic [7:0]           ord_r;
  logic [23:0]          mult_r;
  logic signed [31:0]   cp_r;
  logic signed [31:0]   sp_r;
  logic signed [31:0]   cm_r;
  logic signed [31:0]   sm_r;
  logic signed [63:0]   basec_r;
  logic signed [63:0]   bases_r;
  logic [31:0]          arg_r [6];
  logic signed [31:0]   m1_r;
  logic signed [31:0]   m2_r;
  logic                 cache_vld_r;
  logic [7:0]           cache_tide_r;
  logic signed [31:0]   cache_cos_r;
  logic signed [31:0]   cache_sin_r;
  logic [31:0]          theta_r;
  logic signed [PW-1:0] acc_r;
  logic signed [CW-1:0] dc_r;
  logic signed [CW-1:0] ds_r;
  logic signed [63:0]   oc_r;
  logic signed [63:0]   os_r;
  logic                 st_r;
  logic                 out_valid_r;
  logic                 out_status_r;
  logic signed [63:0]   out_cos_r;
  logic signed [63:0]   out_sin_r;

  logic                 in_bad;
  logic                 need_angle;
  logic [15:0]          tri_w;
  logic [7:0]           idx;
  logic                 pole;
  logic signed [MW-1:0] op_a;
  logic signed [MW-1:0] op_b;
  logic signed [PW-1:0] prod;
  logic signed [PW:0]   rsum;
  logic signed [PW:0]   rshift;
  logic signed [CW-1:0] rnd;
  logic [3:0]           knib;
  logic                 cord_start;
  logic                 cord_done;
  logic signed [31:0]   cord_cos;
  logic signed [31:0]   cord_sin;
  logic signed [SW-1:0] rcos;
  logic signed [SW-1:0] rsin;
  otcc_pkg::store_req_t sreq;

  // Range check and angle cache lookup of the offered transaction.
  assign in_bad     = (in_degree > 8'(NMAX)) || (in_order > in_degree);
  assign need_angle = !cache_vld_r || (in_tide_id != cache_tide_r);

  // Store index n(n+1)/2 + m, modulo 256.
  assign tri_w = {8'd0, deg_r} * ({8'd0, deg_r} + 16'd1);
  assign idx   = tri_w[8:1] + ord_r;
  assign pole  = (deg_r == 8'd2) && (ord_r == 8'd1);

  // Operand selection of the shared multiplier.
  assign knib = mult_r[{cnt_r, 2'b00} +: 4];
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_r == S_TH_MUL) begin
      op_a = MW'(signed'(knib));
      op_b = {1'b0, arg_r[cnt_r]};
    end else if (cmd_r == otcc_pkg::CMD_ADD) begin
      case (cnt_r)
        3'd0: begin
          op_a = {cp_r[31], cp_r} + {cm_r[31], cm_r};
          op_b = MW'(cache_cos_r);
        end
        3'd1: begin
          op_a = {sp_r[31], sp_r} + {sm_r[31], sm_r};
          op_b = MW'(cache_sin_r);
        end
        3'd2: begin
          op_a = {cm_r[31], cm_r} - {cp_r[31], cp_r};
          op_b = MW'(cache_sin_r);
        end
        default: begin
          op_a = {sp_r[31], sp_r} - {sm_r[31], sm_r};
          op_b = MW'(cache_cos_r);
        end
      endcase
    end else begin
      case (cnt_r)
        3'd0: begin
          op_a = otcc_pkg::POLE_C_M1;
          op_b = MW'(m1_r);
        end
        3'd1: begin
          op_a = otcc_pkg::POLE_C_M2;
          op_b = MW'(m2_r);
        end
        3'd2: begin
          op_a = otcc_pkg::POLE_S_M1;
          op_b = MW'(m1_r);
        end
        default: begin
          op_a = otcc_pkg::POLE_S_M2;
          op_b = MW'(m2_r);
        end
      endcase
    end
  end

  // Sum of two products, rounded half up: by 2^30 for rows, 2^40 for the pole.
  always_comb begin
    if (cmd_r == otcc_pkg::CMD_ADD) begin
      rsum   = {acc_r[PW-1], acc_r} + {prod[PW-1], prod} + (PW+1)'(64'sd536870912);
      rshift = rsum >>> 30;
    end else begin
      rsum   = {acc_r[PW-1], acc_r} + {prod[PW-1], prod} + (PW+1)'(64'sd549755813888);
      rshift = rsum >>> 40;
    end
    rnd = rshift[CW-1:0];
  end

  assign cord_start = (state_r == S_CORD_GO);

  // Store request.
  always_comb begin
    sreq.clr  = (state_r == S_IDLE) && in_valid && (in_command == otcc_pkg::CMD_CLR);
    sreq.we   = (state_r == S_WRITE);
    sreq.idx  = idx;
    sreq.wcos = otcc_pkg::sat48({rcos[SW-1], rcos} + (SW+1)'(dc_r));
    sreq.wsin = otcc_pkg::sat48({rsin[SW-1], rsin} + (SW+1)'(ds_r));
  end

  otcc_mul u_mul (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .p_r (prod)
  );

  otcc_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cord_start),
    .angle  (theta_r),
    .done_r (cord_done),
    .cos_r  (cord_cos),
    .sin_r  (cord_sin)
  );

  otcc_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sreq),
    .rcos  (rcos),
    .rsin  (rsin)
  );

  // Sequencer, configuration registers, angle cache and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= 3'd0;
      out_valid_r  <= 1'b0;
      cache_vld_r  <= 1'b0;
      cache_tide_r <= 8'd0;
      cache_cos_r  <= '0;
      cache_sin_r  <= '0;
      m1_r         <= '0;
      m2_r         <= '0;
      for (int i = 0; i < 6; i++) begin
        arg_r[i] <= '0;
      end
    end else begin
      // Configuration writes.
      if (cfg_we) begin
        if (cfg_index == otcc_pkg::REG_POLE_M1) begin
          m1_r <= cfg_data;
        end else if (cfg_index == otcc_pkg::REG_POLE_M2) begin
          m2_r <= cfg_data;
        end else begin
          arg_r[cfg_index] <= cfg_data;
        end
      end

      // A new angle or a clear drops the cached cosine and sine.
      if (sreq.clr || (cfg_we && (cfg_index < otcc_pkg::REG_POLE_M1))) begin
        cache_vld_r <= 1'b0;
      end

      // The output register empties when taken, unless a new result replaces it.
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_command;
            deg_r   <= in_degree;
            ord_r   <= in_order;
            mult_r  <= in_doodson_multipliers;
            cp_r    <= in_cos_plus_amp;
            sp_r    <= in_sin_plus_amp;
            cm_r    <= in_cos_minus_amp;
            sm_r    <= in_sin_minus_amp;
            basec_r <= in_base_cos_coeff;
            bases_r <= in_base_sin_coeff;
            oc_r    <= '0;
            os_r    <= '0;
            st_r    <= 1'b0;
            cnt_r   <= 3'd0;
            theta_r <= '0;
            state_r <= S_OUT;
            unique case (in_command)
              otcc_pkg::CMD_ADD: begin
                if (in_bad) begin
                  st_r <= 1'b1;
                end else if (need_angle) begin
                  cache_tide_r <= in_tide_id;
                  state_r      <= S_TH_MUL;
                end else begin
                  state_r <= S_MUL;
                end
              end
              otcc_pkg::CMD_READ: begin
                if (in_bad) begin
                  st_r <= 1'b1;
                end else begin
                  state_r <= S_RD_WAIT;
                end
              end
              default: ;
            endcase
          end
        end
        // Argument: sum of multiplier times Doodson angle, modulo one turn.
        S_TH_MUL: begin
          state_r <= S_TH_ACC;
        end
        S_TH_ACC: begin
          theta_r <= theta_r + prod[31:0];
          if (cnt_r == 3'd5) begin
            state_r <= S_CORD_GO;
          end else begin
            cnt_r   <= cnt_r + 3'd1;
            state_r <= S_TH_MUL;
          end
        end
        S_CORD_GO: begin
          state_r <= S_CORD_WAIT;
        end
        S_CORD_WAIT: begin
          if (cord_done) begin
            cache_cos_r <= cord_cos;
            cache_sin_r <= cord_sin;
            cache_vld_r <= 1'b1;
            cnt_r       <= 3'd0;
            state_r     <= S_MUL;
          end
        end
        // Products in pairs; the second of a pair closes a rounded sum.
        S_MUL: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (!cnt_r[0]) begin
            acc_r   <= prod;
            cnt_r   <= cnt_r + 3'd1;
            state_r <= S_MUL;
          end else if (cnt_r == 3'd1) begin
            dc_r <= rnd;
            if (cmd_r == otcc_pkg::CMD_ADD && ord_r == 8'd0) begin
              ds_r    <= '0;
              state_r <= S_WRITE;
            end else begin
              cnt_r   <= cnt_r + 3'd1;
              state_r <= S_MUL;
            end
          end else begin
            ds_r    <= rnd;
            state_r <= (cmd_r == otcc_pkg::CMD_ADD) ? S_WRITE : S_RD_POLE;
          end
        end
        S_WRITE: begin
          state_r <= S_OUT;
        end
        // Read: base plus stored correction, then the pole tide.
        S_RD_WAIT: begin
          state_r <= S_RD_SUM;
        end
        S_RD_SUM: begin
          oc_r <= otcc_pkg::sat_add64(basec_r, 64'(rcos));
          os_r <= otcc_pkg::sat_add64(bases_r, 64'(rsin));
          cnt_r <= 3'd0;
          if (pole) begin
            state_r <= S_MUL;
          end else begin
            dc_r    <= '0;
            ds_r    <= '0;
            state_r <= S_RD_POLE;
          end
        end
        S_RD_POLE: begin
          oc_r    <= otcc_pkg::sat_add64(oc_r, 64'(dc_r));
          os_r    <= otcc_pkg::sat_add64(os_r, 64'(ds_r));
          state_r <= S_OUT;
        end
        // Hand the result to the output register once it is free.
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= st_r;
            out_cos_r    <= oc_r;
            out_sin_r    <= os_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready                = (state_r == S_IDLE);
  assign out_valid               = out_valid_r;
  assign out_status              = out_status_r;
  assign out_corrected_cos_coeff = out_cos_r;
  assign out_corrected_sin_coeff = out_sin_r;

endmodule
`default_nettype wire

>>> design/otcc_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 33 by 33 bit multiplier with a registered product.
// ----------------------------------------------------------------------------
module otcc_mul (
  input  wire logic                                   clk,
  input  wire logic signed [otcc_pkg::MUL_W-1:0]      a,
  input  wire logic signed [otcc_pkg::MUL_W-1:0]      b,
  output logic signed [otcc_pkg::PROD_W-1:0]          p_r
);

  // The product is registered before anything uses it.
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule
`default_nettype wire

>>> design/otcc_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative CORDIC rotator
// Turns an angle in fractions of a turn into cosine and sine, Q2.30, with one
// shift-and-add step per cycle.
// ----------------------------------------------------------------------------
module otcc_cordic (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [31:0]        angle,
  output logic                    done_r,
  output logic signed [31:0]      cos_r,
  output logic signed [31:0]      sin_r
);

  localparam int W = otcc_pkg::CORD_W;

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

  cstate_t             state_r;
  logic [4:0]          step_r;
  logic                flip_r;
  logic signed [W-1:0] x_r;
  logic signed [W-1:0] y_r;
  logic signed [W-1:0] z_r;
  logic signed [W-1:0] dx;
  logic signed [W-1:0] dy;
  logic signed [W-1:0] da;
  logic signed [W-1:0] xf;
  logic signed [W-1:0] yf;
  logic                flip_in;
  logic [31:0]         ang_in;

  // Saturate the rotator width to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [W-1:0] v);
    logic signed [31:0] r;
    if (v > W'(signed'(32'h7FFFFFFF))) begin
      r = 32'sh7FFFFFFF;
    end else if (v < W'(signed'(32'h80000000))) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Angles in the left half plane are turned by half a turn.
  assign flip_in = angle[31] ^ angle[30];
  assign ang_in  = flip_in ? (angle ^ 32'h80000000) : angle;

  // One micro-rotation of the shared step.
  assign dx = y_r >>> step_r;
  assign dy = x_r >>> step_r;
  assign da = W'(otcc_pkg::atan_turn(step_r));
  assign xf = flip_r ? -x_r : x_r;
  assign yf = flip_r ? -y_r : y_r;

  // Step sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
      step_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            x_r     <= otcc_pkg::CORDIC_GAIN;
            y_r     <= '0;
            z_r     <= W'(signed'(ang_in));
            flip_r  <= flip_in;
            step_r  <= 5'd0;
            state_r <= C_RUN;
          end
        end
        C_RUN: begin
          if (!z_r[W-1]) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - da;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + da;
          end
          if (step_r == 5'(otcc_pkg::CORD_STEPS - 1)) begin
            state_r <= C_FIN;
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        C_FIN: begin
          cos_r   <= sat32(xf);
          sin_r   <= sat32(yf);
          done_r  <= 1'b1;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/otcc_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Correction store
// Two 256-entry memories of cosine and sine corrections with per-entry valid
// bits, so that reset and clear take effect at once.
// ----------------------------------------------------------------------------
module otcc_store (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire otcc_pkg::store_req_t                   req,
  output logic signed [otcc_pkg::STORE_W-1:0]         rcos,
  output logic signed [otcc_pkg::STORE_W-1:0]         rsin
);

  localparam int SW = otcc_pkg::STORE_W;

  logic signed [SW-1:0] cos_mem [256];
  logic signed [SW-1:0] sin_mem [256];
  logic [255:0]         vld_r;
  logic signed [SW-1:0] rcos_r;
  logic signed [SW-1:0] rsin_r;
  logic                 rvld_r;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (req.we) begin
      cos_mem[req.idx] <= req.wcos;
      sin_mem[req.idx] <= req.wsin;
    end
    rcos_r <= cos_mem[req.idx];
    rsin_r <= sin_mem[req.idx];
  end

  // Valid bits: an entry not yet written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[req.idx] & ~req.clr;
      if (req.clr) begin
        vld_r <= '0;
      end else if (req.we) begin
        vld_r[req.idx] <= 1'b1;
      end
    end
  end

  assign rcos = rvld_r ? rcos_r : '0;
  assign rsin = rvld_r ? rsin_r : '0;

endmodule
`default_nettype wire

>>> tb/tb_ocean_tide_coeff_correction.sv
// ----------------------------------------------------------------------------
// Ocean tide coefficient correction testbench
// Drives add, read, clear and unknown transactions into the correction block
// under random idling on both channels, predicts results with a local model
// of the CORDIC, the correction store and the pole tide, or takes them from a
// directed table, and compares each result field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_ocean_tide_coeff_correction;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam longint STORE_HI = 64'sd140737488355327;
  localparam longint STORE_LO = -64'sd140737488355328;

  typedef struct {
    logic [1:0]  command;
    logic [7:0]  tide_id;
    logic [7:0]  degree;
    logic [7:0]  order;
    logic [23:0] mults;
    logic [31:0] cp, sp, cm, sm;
    logic [63:0] base_cos, base_sin;
  } tide_txn_t;

  typedef struct {
    logic        status;
    logic [63:0] cos_coeff;
    logic [63:0] sin_coeff;
  } coeff_result_t;

  typedef struct {
    tide_txn_t     txn;
    bit            typed;
    coeff_result_t res;
  } directed_row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] in_command;
  logic [7:0] in_tide_id, in_degree, in_order;
  logic [23:0] in_doodson_multipliers;
  logic signed [31:0] in_cos_plus_amp, in_sin_plus_amp, in_cos_minus_amp, in_sin_minus_amp;
  logic signed [63:0] in_base_cos_coeff, in_base_sin_coeff;
  logic out_valid, out_ready, out_status;
  logic signed [63:0] out_corrected_cos_coeff, out_corrected_sin_coeff;

  ocean_tide_coeff_correction dut (.*);

  // Predictor state.
  logic [31:0]   angle_reg [6];
  logic [31:0]   pole_m1_reg, pole_m2_reg;
  bit            angle_ok;
  logic [7:0]    angle_tide;
  longint        angle_cos, angle_sin;
  longint        cos_corr [256];
  longint        sin_corr [256];
  coeff_result_t coeff_q[$];
  int            mismatches;
  bit            calm;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #20000000;
    $display("tb_ocean_tide_coeff_correction: FAIL");
    $finish;
  end

  function automatic longint round_dot30(longint a, longint c, longint b, longint s);
    longint p1, p2, q1, q2;
    p1 = a * c;
    p2 = b * s;
    q1 = p1 >>> 30;
    q2 = p2 >>> 30;
    return q1 + q2 + (((p1 - (q1 <<< 30)) + (p2 - (q2 <<< 30)) + 64'sd536870912) >>> 30);
  endfunction

  function automatic longint clamp48(longint v);
    return v > STORE_HI ? STORE_HI : (v < STORE_LO ? STORE_LO : v);
  endfunction

  function automatic longint add_sat64(longint a, longint b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic longint pole_tide(longint k1, longint k2);
    longint p;
    p = k1 * longint'($signed(pole_m1_reg)) + k2 * longint'($signed(pole_m2_reg));
    return (p + 64'sd549755813888) >>> 40;
  endfunction

  function automatic longint clamp32(longint v);
    return v > 64'sd2147483647 ? 64'sd2147483647 :
           (v < -64'sd2147483648 ? -64'sd2147483648 : v);
  endfunction

  // Rotate to the tide argument and leave cosine and sine in the cache.
  task automatic rotate_angle(logic [31:0] ang);
    bit     flip;
    longint x, y, z, dx, dy;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang[31] = ~ang[31];
    x = otcc_pkg::CORDIC_GAIN;
    y = 0;
    z = longint'($signed(ang));
    for (int i = 0; i < otcc_pkg::CORD_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(otcc_pkg::atan_turn(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(otcc_pkg::atan_turn(i[4:0]));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    angle_cos = clamp32(x);
    angle_sin = clamp32(y);
  endtask

  // Predict the result of one transaction and update the predicted state.
  task automatic predict_coeff(tide_txn_t t, output coeff_result_t r);
    bit          skip;
    logic [7:0]  idx;
    logic [31:0] theta;
    longint      cp, sp, cm, sm, dc, ds, k;
    skip = (t.degree > otcc_pkg::NMAX) || (t.order > t.degree);
    idx = 8'((int'(t.degree) * (int'(t.degree) + 1)) / 2 + int'(t.order));
    r = '{1'b0, 64'd0, 64'd0};
    case (t.command)
      otcc_pkg::CMD_ADD: begin
        if (skip) r.status = 1'b1;
        else begin
          cp = longint'($signed(t.cp));
          sp = longint'($signed(t.sp));
          cm = longint'($signed(t.cm));
          sm = longint'($signed(t.sm));
          if (!angle_ok || t.tide_id != angle_tide) begin
            theta = 32'd0;
            for (int i = 0; i < 6; i++) begin
              k = longint'($signed(t.mults[4*i +: 4]));
              theta += 32'(k * longint'(angle_reg[i]));
            end
            rotate_angle(theta);
            angle_tide = t.tide_id;
            angle_ok = 1'b1;
          end
          dc = round_dot30(cp + cm, angle_cos, sp + sm, angle_sin);
          ds = (t.order != 0) ? round_dot30(cm - cp, angle_sin, sp - sm, angle_cos) : 0;
          cos_corr[idx] = clamp48(cos_corr[idx] + dc);
          sin_corr[idx] = clamp48(sin_corr[idx] + ds);
        end
      end
      otcc_pkg::CMD_READ: begin
        if (skip) r.status = 1'b1;
        else begin
          r.cos_coeff = add_sat64(t.base_cos, cos_corr[idx]);
          r.sin_coeff = add_sat64(t.base_sin, sin_corr[idx]);
          if (t.degree == 8'd2 && t.order == 8'd1) begin
            r.cos_coeff = add_sat64(r.cos_coeff,
                                    pole_tide(otcc_pkg::POLE_C_M1, otcc_pkg::POLE_C_M2));
            r.sin_coeff = add_sat64(r.sin_coeff,
                                    pole_tide(otcc_pkg::POLE_S_M1, otcc_pkg::POLE_S_M2));
          end
        end
      end
      otcc_pkg::CMD_CLR: begin
        for (int i = 0; i < 256; i++) begin
          cos_corr[i] = 0;
          sin_corr[i] = 0;
        end
        angle_ok = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    mismatches++;
  endtask

  // Write one register and mirror it in the predictor.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == otcc_pkg::REG_POLE_M1) pole_m1_reg = val;
    else if (idx == otcc_pkg::REG_POLE_M2) pole_m2_reg = val;
    else begin
      angle_reg[idx] = val;
      angle_ok = 1'b0;
    end
  endtask

  // Wait for the block to go quiet before touching registers.
  task automatic wait_quiet();
    wait (coeff_q.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  // Send one transaction; random idling gaps may be inserted ahead of it.
  task automatic send_txn(tide_txn_t t, bit typed, coeff_result_t want);
    coeff_result_t r;
    if (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6) + 1) @(posedge clk);
    end else if (!in_valid) begin
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= t.command;
    in_tide_id <= t.tide_id;
    in_degree <= t.degree;
    in_order <= t.order;
    in_doodson_multipliers <= t.mults;
    in_cos_plus_amp <= t.cp;
    in_sin_plus_amp <= t.sp;
    in_cos_minus_amp <= t.cm;
    in_sin_minus_amp <= t.sm;
    in_base_cos_coeff <= t.base_cos;
    in_base_sin_coeff <= t.base_sin;
    do @(posedge clk); while (!in_ready);
    predict_coeff(t, r);
    coeff_q.insert(coeff_q.size(), typed ? want : r);
  endtask

  // Drop valid at the edge that took the last transaction.
  task automatic finish_burst();
    in_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_amp();
    case ($urandom_range(9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_base();
    case ($urandom_range(9))
      0: return 64'h7FFFFFFFFFFFFFFF;
      1: return 64'h8000000000000000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly well-formed rows on a few tide ids, with reads and rare clears.
  function automatic tide_txn_t random_txn();
    tide_txn_t t;
    int sel;
    sel = $urandom_range(99);
    t.command = sel < 55 ? otcc_pkg::CMD_ADD :
                sel < 88 ? otcc_pkg::CMD_READ :
                sel < 94 ? otcc_pkg::CMD_CLR : CMD_UNKNOWN;
    t.tide_id = $urandom_range(9) < 8 ? 8'($urandom_range(3)) : 8'($urandom);
    if ($urandom_range(9) == 0) begin
      t.degree = 8'($urandom);
      t.order = 8'($urandom);
    end else begin
      t.degree = 8'($urandom_range(otcc_pkg::NMAX));
      t.order = 8'($urandom_range(t.degree));
    end
    t.mults = 24'($urandom);
    t.cp = pick_amp();
    t.sp = pick_amp();
    t.cm = pick_amp();
    t.sm = pick_amp();
    t.base_cos = pick_base();
    t.base_sin = pick_base();
    return t;
  endfunction

  // Result side: random backpressure and in-order checking.
  always @(posedge clk) begin
    coeff_result_t w;
    if (!rst_n) out_ready <= 1'b0;
    else begin
      if (out_valid && out_ready) begin
        if (coeff_q.size() == 0) begin
          report_mismatch("unexpected result", out_corrected_cos_coeff, 64'd0);
        end else begin
          w = coeff_q.pop_front();
          if (out_status !== w.status)
            report_mismatch("status", 64'(out_status), 64'(w.status));
          if (out_corrected_cos_coeff !== w.cos_coeff)
            report_mismatch("cos", out_corrected_cos_coeff, w.cos_coeff);
          if (out_corrected_sin_coeff !== w.sin_coeff)
            report_mismatch("sin", out_corrected_sin_coeff, w.sin_coeff);
        end
      end
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
    end
  end

  // Stimulus.
  initial begin
    directed_row_t rows[$];
    tide_txn_t     t;
    coeff_result_t nil;
    nil = '{1'b0, 64'd0, 64'd0};
    mismatches = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_command = otcc_pkg::CMD_ADD;
    in_tide_id = '0;
    in_degree = '0;
    in_order = '0;
    in_doodson_multipliers = '0;
    in_cos_plus_amp = '0;
    in_sin_plus_amp = '0;
    in_cos_minus_amp = '0;
    in_sin_minus_amp = '0;
    in_base_cos_coeff = '0;
    in_base_sin_coeff = '0;
    for (int i = 0; i < 6; i++) angle_reg[i] = '0;
    pole_m1_reg = '0;
    pole_m2_reg = '0;
    angle_ok = 1'b0;
    angle_tide = '0;
    angle_cos = 0;
    angle_sin = 0;
    for (int i = 0; i < 256; i++) begin
      cos_corr[i] = 0;
      sin_corr[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed table: reset reads, range errors, unknown command, extremes.
    t = '{otcc_pkg::CMD_READ, 8'd0, 8'd0, 8'd0, 24'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          64'h7FFFFFFFFFFFFFFF, 64'h8000000000000000};
    rows.insert(rows.size(),
                '{t, 1'b1, '{1'b0, 64'h7FFFFFFFFFFFFFFF, 64'h8000000000000000}});
    t.degree = 8'd2; t.order = 8'd1; t.base_cos = 64'd5; t.base_sin = -64'sd5;
    rows.insert(rows.size(), '{t, 1'b1, '{1'b0, 64'd5, -64'sd5}});
    t.degree = 8'd16; t.order = 8'd0;
    rows.insert(rows.size(), '{t, 1'b1, '{1'b1, 64'd0, 64'd0}});
    t.degree = 8'd3; t.order = 8'd4;
    rows.insert(rows.size(), '{t, 1'b1, '{1'b1, 64'd0, 64'd0}});
    t.command = otcc_pkg::CMD_ADD; t.degree = 8'd255; t.order = 8'd255;
    rows.insert(rows.size(), '{t, 1'b1, '{1'b1, 64'd0, 64'd0}});
    t.command = CMD_UNKNOWN; t.degree = 8'd2; t.order = 8'd1;
    rows.insert(rows.size(), '{t, 1'b1, nil});
    t.command = otcc_pkg::CMD_CLR;
    rows.insert(rows.size(), '{t, 1'b1, nil});
    // Order zero row, then a row at top degree with extreme amplitudes.
    t = '{otcc_pkg::CMD_ADD, 8'd7, 8'd4, 8'd0, 24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000,
          32'h7FFFFFFF, 32'h80000000, 64'd0, 64'd0};
    rows.insert(rows.size(), '{t, 1'b0, nil});
    t.command = otcc_pkg::CMD_READ;
    rows.insert(rows.size(), '{t, 1'b0, nil});
    t = '{otcc_pkg::CMD_ADD, 8'd255, 8'd15, 8'd15, 24'h888888, 32'h80000000, 32'h7FFFFFFF,
          32'h7FFFFFFF, 32'h80000000, 64'd0, 64'd0};
    rows.insert(rows.size(), '{t, 1'b0, nil});
    t.tide_id = 8'd0; t.mults = 24'h777777;
    rows.insert(rows.size(), '{t, 1'b0, nil});
    t.command = otcc_pkg::CMD_READ;
    t.base_cos = 64'h7FFFFFFFFFFFFFFF; t.base_sin = 64'h8000000000000000;
    rows.insert(rows.size(), '{t, 1'b0, nil});
    t.command = otcc_pkg::CMD_ADD; t.degree = 8'd1; t.order = 8'd1;
    rows.insert(rows.size(), '{t, 1'b0, nil});
    t.command = otcc_pkg::CMD_CLR;
    rows.insert(rows.size(), '{t, 1'b1, nil});
    t.command = otcc_pkg::CMD_READ; t.base_cos = 64'd0; t.base_sin = 64'd0;
    rows.insert(rows.size(), '{t, 1'b1, '{1'b0, 64'd0, 64'd0}});
    t.base_cos = 64'h7FFFFFFFFFFFFFFF; t.base_sin = 64'h8000000000000000;
    rows.insert(rows.size(),
                '{t, 1'b1, '{1'b0, 64'h7FFFFFFFFFFFFFFF, 64'h8000000000000000}});
    foreach (rows[i]) send_txn(rows[i].txn, rows[i].typed, rows[i].res);
    finish_burst();

    // Random phases, each after a fresh register setting.
    for (int phase = 0; phase < 4; phase++) begin
      wait_quiet();
      for (int r = 0; r < 8; r++) begin
        case (phase)
          0: write_reg(3'(r), $urandom);
          1: write_reg(3'(r), r < 6 ? 32'hFFFFFFFF :
                       (r == otcc_pkg::REG_POLE_M1 ? 32'h7FFFFFFF : 32'h80000000));
          2: write_reg(3'(r), r < 6 ? 32'h0 :
                       (r == otcc_pkg::REG_POLE_M1 ? 32'h80000000 : 32'h7FFFFFFF));
          default: write_reg(3'(r), $urandom);
        endcase
      end
      calm = (phase == 2);
      for (int n = 0; n < 435; n++) send_txn(random_txn(), 1'b0, nil);
      finish_burst();
      calm = 1'b0;
    end

    wait (coeff_q.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("tb_ocean_tide_coeff_correction: PASS");
    else $display("tb_ocean_tide_coeff_correction: FAIL");
    $finish;
  end

endmodule

>>> ocean_tide_coeff_correction.f
design/otcc_pkg.sv
design/otcc_mul.sv
design/otcc_cordic.sv
design/otcc_store.sv
design/ocean_tide_coeff_correction.sv
tb/tb_ocean_tide_coeff_correction.sv
